>>> rtl/gbkn_pkg.sv
// Shared types and constants for the grid-binned keypoint neighbour search.
// Holds command and status codes, the controller/datapath interface structs
// and the parameter defaults. Depends on nothing.
`default_nettype none

package gbkn_pkg;

    localparam int MAX_POINTS_DEF  = 1024;
    localparam int CELL_SIZE_DEF   = 16;
    localparam int MAX_MATCHES_DEF = 64;

    localparam int CFG_W = 12;
    localparam logic [CFG_W-1:0] FRAME_W_RST = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_H_RST = 12'd480;

    // Register index as decoded from paddr[2]
    localparam logic REG_FRAME_W = 1'b0;
    localparam logic REG_FRAME_H = 1'b1;

    // Reciprocal shift for dividing pixel values by the cell size
    localparam int RECIP_SHIFT = 20;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OUTSIDE = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef struct packed {
        logic take_in;
        logic clear_store;
        logic scan_start;
        logic scan_rd;
        logic feed_load;
        logic load_commit;
        logic emit_empty;
        logic emit_head;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t new_cmd;
        logic scan_done;
        logic pipe_busy;
        logic out_free;
        logic list_empty;
        logic list_one;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/gbkn_ctrl.sv
// Controller state machine for the neighbour search: sequences clear, load
// and query requests and drives the datapath. Depends on gbkn_pkg.
`default_nettype none

module gbkn_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire gbkn_pkg::dp_stat_t stat,
    output gbkn_pkg::dp_cmd_t      cmd
);
    import gbkn_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD_FEED,
        S_LOAD_WAIT,
        S_LOAD_DONE,
        S_SCAN,
        S_DRAIN,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.take_in = 1'b1;
                    case (stat.new_cmd)
                        CMD_CLEAR: cmd.clear_store = 1'b1;
                        CMD_LOAD:  state_next = S_LOAD_FEED;
                        CMD_QUERY:
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_LOAD_FEED:
            begin
                cmd.feed_load = 1'b1;
                state_next    = S_LOAD_WAIT;
            end
            S_LOAD_WAIT: state_next = S_LOAD_DONE;
            S_LOAD_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_commit = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                    state_next = S_DRAIN;
                else
                    cmd.scan_rd = 1'b1;
            end
            S_DRAIN:
            begin
                if (!stat.pipe_busy)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    if (stat.list_empty)
                    begin
                        cmd.emit_empty = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        cmd.emit_head = 1'b1;
                        if (stat.list_one)
                            state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

>>> rtl/gbkn_datapath.sv
// Datapath of the neighbour search: configuration registers, point store,
// match pipeline, sorted match list and output register. Depends on gbkn_pkg.
`default_nettype none

module gbkn_datapath #(
    parameter int MAX_POINTS  = gbkn_pkg::MAX_POINTS_DEF,
    parameter int CELL_SIZE   = gbkn_pkg::CELL_SIZE_DEF,
    parameter int MAX_MATCHES = gbkn_pkg::MAX_MATCHES_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    input  wire logic [55:0]       s_tdata,
    input  wire logic [1:0]        s_tuser,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [15:0]            m_tdata,
    output logic [3:0]             m_tuser,
    output logic                   m_tlast,
    input  wire gbkn_pkg::dp_cmd_t cmd,
    output gbkn_pkg::dp_stat_t     stat
);
    import gbkn_pkg::*;

    localparam int AW      = $clog2(MAX_POINTS);
    localparam int CW      = $clog2(MAX_POINTS + 1);
    localparam int MW      = $clog2(MAX_MATCHES + 1);
    localparam int TW      = $clog2(MAX_MATCHES + 2);
    localparam int CELL_W  = $clog2(2047 / CELL_SIZE + 1);
    localparam int GRID_W  = $clog2(4095 / CELL_SIZE + 1);
    localparam int KEY_W   = 2 * CELL_W;
    localparam int PROD_W  = 32;
    localparam int RECIP   = ((1 << RECIP_SHIFT) + CELL_SIZE - 1) / CELL_SIZE;
    localparam logic [PROD_W-1:0] RECIP_L = PROD_W'(RECIP);

    function automatic logic [14:0] abs_diff(input logic [14:0] a, input logic [14:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    // ---------------- configuration ----------------
    logic [CFG_W-1:0]  frame_w_reg;
    logic [CFG_W-1:0]  frame_h_reg;
    logic [GRID_W-1:0] cols_reg;
    logic [GRID_W-1:0] rows_reg;
    logic [PROD_W-1:0] cols_prod;
    logic [PROD_W-1:0] rows_prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_w_reg <= FRAME_W_RST;
            frame_h_reg <= FRAME_H_RST;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_FRAME_W)
                frame_w_reg <= pwdata[CFG_W-1:0];
            else
                frame_h_reg <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata    = (paddr[2] == REG_FRAME_H) ? {20'd0, frame_h_reg} : {20'd0, frame_w_reg};
    assign cols_prod = PROD_W'(frame_w_reg) * RECIP_L;
    assign rows_prod = PROD_W'(frame_h_reg) * RECIP_L;

    always_ff @(posedge clk)
    begin
        cols_reg <= cols_prod[RECIP_SHIFT +: GRID_W];
        rows_reg <= rows_prod[RECIP_SHIFT +: GRID_W];
    end

    // ---------------- request capture ----------------
    cmd_t        in_cmd_reg;
    logic [14:0] in_x_reg;
    logic [14:0] in_y_reg;
    logic [2:0]  in_lvl_reg;
    logic [14:0] in_rad_reg;
    logic [2:0]  in_lo_reg;
    logic [2:0]  in_hi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_cmd_reg <= CMD_NOP;
        else if (cmd.take_in)
            in_cmd_reg <= cmd_t'(s_tuser);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            in_x_reg   <= s_tdata[14:0];
            in_y_reg   <= s_tdata[29:15];
            in_lvl_reg <= s_tdata[32:30];
            in_rad_reg <= s_tdata[47:33];
            in_lo_reg  <= s_tdata[50:48];
            in_hi_reg  <= s_tdata[53:51];
        end
    end

    // ---------------- point store ----------------
    logic [32:0]   mem [MAX_POINTS];
    logic [32:0]   mem_q_reg;
    logic          q_vld_reg;
    logic [AW-1:0] q_idx_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] addr_reg;
    logic          store_full;
    logic          s3_inside_reg;
    logic          load_ok;

    assign store_full = (count_reg == CW'(MAX_POINTS));
    assign load_ok    = s3_inside_reg && !store_full;

    always_ff @(posedge clk)
    begin
        if (cmd.load_commit && load_ok)
            mem[count_reg[AW-1:0]] <= {in_lvl_reg, in_y_reg, in_x_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_rd)
        begin
            mem_q_reg <= mem[addr_reg[AW-1:0]];
            q_idx_reg <= addr_reg[AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            addr_reg  <= '0;
            q_vld_reg <= 1'b0;
        end
        else
        begin
            q_vld_reg <= cmd.scan_rd;
            if (cmd.clear_store)
                count_reg <= '0;
            else if (cmd.load_commit && load_ok)
                count_reg <= count_reg + 1'b1;
            if (cmd.scan_start)
                addr_reg <= '0;
            else if (cmd.scan_rd)
                addr_reg <= addr_reg + 1'b1;
        end
    end

    // ---------------- match pipeline ----------------
    logic [14:0]       cand_x;
    logic [14:0]       cand_y;
    logic [2:0]        cand_l;
    logic              s2_vld_reg;
    logic [PROD_W-1:0] s2_px_reg;
    logic [PROD_W-1:0] s2_py_reg;
    logic              s2_near_reg;
    logic [AW-1:0]     s2_idx_reg;
    logic [CELL_W-1:0] s2_col;
    logic [CELL_W-1:0] s2_row;
    logic              s3_vld_reg;
    logic              s3_match_reg;
    logic [KEY_W-1:0]  s3_key_reg;
    logic [AW-1:0]     s3_idx_reg;

    assign cand_x = q_vld_reg ? mem_q_reg[14:0]  : in_x_reg;
    assign cand_y = q_vld_reg ? mem_q_reg[29:15] : in_y_reg;
    assign cand_l = q_vld_reg ? mem_q_reg[32:30] : in_lvl_reg;
    assign s2_col = s2_px_reg[RECIP_SHIFT +: CELL_W];
    assign s2_row = s2_py_reg[RECIP_SHIFT +: CELL_W];

    always_ff @(posedge clk)
    begin
        if (q_vld_reg || cmd.feed_load)
        begin
            s2_px_reg   <= PROD_W'(cand_x[14:4]) * RECIP_L;
            s2_py_reg   <= PROD_W'(cand_y[14:4]) * RECIP_L;
            s2_near_reg <= (abs_diff(cand_x, in_x_reg) < in_rad_reg)
                        && (abs_diff(cand_y, in_y_reg) < in_rad_reg)
                        && (cand_l >= in_lo_reg) && (cand_l <= in_hi_reg);
            s2_idx_reg  <= q_idx_reg;
        end
        if (s2_vld_reg)
        begin
            s3_inside_reg <= (GRID_W'(s2_col) < cols_reg) && (GRID_W'(s2_row) < rows_reg);
            s3_match_reg  <= s2_near_reg && (GRID_W'(s2_col) < cols_reg)
                          && (GRID_W'(s2_row) < rows_reg);
            s3_key_reg    <= {s2_col, s2_row};
            s3_idx_reg    <= s2_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= q_vld_reg || cmd.feed_load;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    // ---------------- sorted match list ----------------
    logic [KEY_W-1:0]   key_reg [MAX_MATCHES];
    logic [AW-1:0]      idx_reg [MAX_MATCHES];
    logic [MW-1:0]      kept_reg;
    logic [TW-1:0]      total_reg;
    logic [MAX_MATCHES-1:0] big;
    logic               do_insert;

    assign do_insert = s3_vld_reg && s3_match_reg && (in_cmd_reg == CMD_QUERY);

    // Entries at or past the insert point move up one place
    always_comb
    begin
        for (int j = 0; j < MAX_MATCHES; j++)
            big[j] = (MW'(j) >= kept_reg) || (key_reg[j] > s3_key_reg);
    end

    always_ff @(posedge clk)
    begin
        if (do_insert)
        begin
            for (int j = 0; j < MAX_MATCHES; j++)
            begin
                if (j > 0 && big[(j > 0) ? j - 1 : 0])
                begin
                    key_reg[j] <= key_reg[(j > 0) ? j - 1 : 0];
                    idx_reg[j] <= idx_reg[(j > 0) ? j - 1 : 0];
                end
                else if (big[j])
                begin
                    key_reg[j] <= s3_key_reg;
                    idx_reg[j] <= s3_idx_reg;
                end
            end
        end
        else if (cmd.emit_head)
        begin
            for (int j = 0; j < MAX_MATCHES - 1; j++)
            begin
                key_reg[j] <= key_reg[j + 1];
                idx_reg[j] <= idx_reg[j + 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_reg  <= '0;
            total_reg <= '0;
        end
        else if (cmd.scan_start)
        begin
            kept_reg  <= '0;
            total_reg <= '0;
        end
        else if (do_insert)
        begin
            if (kept_reg < MW'(MAX_MATCHES))
                kept_reg <= kept_reg + 1'b1;
            if (total_reg <= TW'(MAX_MATCHES))
                total_reg <= total_reg + 1'b1;
        end
        else if (cmd.emit_head)
        begin
            kept_reg <= kept_reg - 1'b1;
        end
    end

    // ---------------- output register ----------------
    logic          out_vld_reg;
    logic [AW-1:0] out_idx_reg;
    logic          out_found_reg;
    logic          out_last_reg;
    logic          out_trunc_reg;
    status_t       out_status_reg;
    logic          out_free;

    assign out_free = !out_vld_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (cmd.load_commit || cmd.emit_empty || cmd.emit_head)
            out_vld_reg <= 1'b1;
        else if (m_tready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_commit)
        begin
            out_idx_reg    <= load_ok ? count_reg[AW-1:0] : '0;
            out_found_reg  <= load_ok;
            out_last_reg   <= 1'b1;
            out_trunc_reg  <= 1'b0;
            out_status_reg <= !s3_inside_reg ? ST_OUTSIDE : (store_full ? ST_FULL : ST_OK);
        end
        else if (cmd.emit_empty)
        begin
            out_idx_reg    <= '0;
            out_found_reg  <= 1'b0;
            out_last_reg   <= 1'b1;
            out_trunc_reg  <= 1'b0;
            out_status_reg <= ST_OK;
        end
        else if (cmd.emit_head)
        begin
            out_idx_reg    <= idx_reg[0];
            out_found_reg  <= 1'b1;
            out_last_reg   <= (kept_reg == MW'(1));
            out_trunc_reg  <= (total_reg > TW'(MAX_MATCHES));
            out_status_reg <= ST_OK;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, 10'(out_idx_reg)};
    assign m_tuser  = {out_status_reg, out_trunc_reg, out_found_reg};
    assign m_tlast  = out_last_reg;

    assign stat.new_cmd    = cmd_t'(s_tuser);
    assign stat.scan_done  = (addr_reg == count_reg);
    assign stat.pipe_busy  = q_vld_reg || s2_vld_reg || s3_vld_reg;
    assign stat.out_free   = out_free;
    assign stat.list_empty = (kept_reg == '0);
    assign stat.list_one   = (kept_reg == MW'(1));

endmodule

`default_nettype wire

>>> rtl/grid_binned_keypoint_neighbour_search.sv
// Top level of the grid-binned keypoint neighbour search.
// Instantiates gbkn_ctrl and gbkn_datapath; depends on gbkn_pkg.
//
// Usage: requests arrive on the s_ channel; s_tuser is the command (clear,
// load, query, or an ignored fourth code). Results leave on the m_ channel,
// m_tlast marking the final result of a request. Frame width and height are
// written over the APB port (offsets 0 and 4) while the block is idle.
// Request handling: one request at a time. A clear or ignored code is acted on
// as it is taken and leaves the block idle. A load passes through input
// capture, the multiplier stage, the cell compare and the commit to its result.
// A query reads the point store one entry per cycle through its single read
// port, then, once the match pipeline has drained, gives one result per cycle
// while m_tready is high, up to MAX_MATCHES results; the sorted match list takes one insertion a cycle.
// Reset empties the store and restores the 640 x 480 frame. When the receiver
// stalls, the output register holds its result and the block waits before
// writing the next one; a new request is taken once the last result is queued.
`default_nettype none

module grid_binned_keypoint_neighbour_search #(
    parameter int MAX_POINTS  = gbkn_pkg::MAX_POINTS_DEF,
    parameter int CELL_SIZE   = gbkn_pkg::CELL_SIZE_DEF,
    parameter int MAX_MATCHES = gbkn_pkg::MAX_MATCHES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // pos_x[14:0], pos_y[29:15], level[32:30], radius[47:33],
    // level_lo[50:48], level_hi[53:51], zero[55:54]
    input  wire logic [55:0] s_tdata,
    // cmd[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // point_index[9:0], zero[15:10]
    output logic [15:0]      m_tdata,
    // found[0], truncated[1], status[3:2]
    output logic [3:0]       m_tuser,
    output logic             m_tlast
);
    import gbkn_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign pready = 1'b1;

    gbkn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gbkn_datapath #(
        .MAX_POINTS  (MAX_POINTS),
        .CELL_SIZE   (CELL_SIZE),
        .MAX_MATCHES (MAX_MATCHES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

`default_nettype wire

>>> rtl/gbkn_checker.sv
// Port-level checks for the neighbour search, bound to the top level.
// Depends on gbkn_pkg and grid_binned_keypoint_neighbour_search.
`default_nettype none

module gbkn_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [3:0]  m_tuser,
    input wire logic        m_tlast
);
    import gbkn_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A load, once taken, drops s_tready
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == CMD_LOAD) |=> !s_tready)
        else $error("request taken during a load");

    // A result without a valid index ends its request
    a_notfound_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast)
        else $error("empty result not marked last");

    // Truncation is only flagged on query matches
    a_trunc_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tuser[0] && (m_tuser[3:2] == ST_OK))
        else $error("truncation on a non-match");

endmodule

bind grid_binned_keypoint_neighbour_search gbkn_checker u_gbkn_checker (.*);

`default_nettype wire
